@@ hdl/tpot_pkg.sv @@
// Shared types, constants and codes of the TCP passive-open tracker.
`default_nettype none

package tpot_pkg;

	// Table size and the index width that follows from it.
	localparam int CONNECTIONS = 16;
	localparam int SLOT_W = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;

	// Configuration port geometry and register indexes.
	localparam int APB_ADDR_W = 3;
	localparam int REG_IDX_W = APB_ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_ISN_SEED = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_RX_WINDOW = REG_IDX_W'(1);
	localparam logic [31:0] ISN_SEED_RESET = 32'd0;
	localparam logic [15:0] RX_WINDOW_RESET = 16'hffff;

	// Stream widths.
	localparam int S_TDATA_W = 112;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 120;
	localparam int M_TUSER_W = 3;

	// Item kinds.
	localparam logic [1:0] OP_SEGMENT = 2'd0;
	localparam logic [1:0] OP_SEND = 2'd1;
	localparam logic [1:0] OP_CLOSE = 2'd2;

	// Result codes.
	localparam logic [2:0] OC_IGNORED = 3'd0;
	localparam logic [2:0] OC_SYNACK = 3'd1;
	localparam logic [2:0] OC_ESTABLISHED = 3'd2;
	localparam logic [2:0] OC_ACK_MISMATCH = 3'd3;
	localparam logic [2:0] OC_DELIVERED = 3'd4;
	localparam logic [2:0] OC_DATA_SENT = 3'd5;
	localparam logic [2:0] OC_SEND_REFUSED = 3'd6;
	localparam logic [2:0] OC_CLOSED = 3'd7;

	// Connection states.
	localparam logic [1:0] ST_LISTEN = 2'd0;
	localparam logic [1:0] ST_SYN_RECV = 2'd1;
	localparam logic [1:0] ST_ESTABLISHED = 2'd2;

	// TCP flag bits and fixed header values.
	localparam logic [7:0] FLAG_SYN = 8'h02;
	localparam logic [7:0] FLAG_PSH = 8'h08;
	localparam logic [7:0] FLAG_ACK = 8'h10;
	localparam logic [7:0] FLAGS_SYNACK = FLAG_SYN | FLAG_ACK;
	localparam logic [7:0] FLAGS_ACKPSH = FLAG_ACK | FLAG_PSH;
	localparam logic [7:0] HDR_BYTE_FIVE = 8'h50;
	localparam logic [31:0] ISN_STEP = 32'h9e3779b1;
	localparam logic [17:0] MIN_HDR_BYTES = 18'd20;

	// One input request.
	typedef struct packed {
		logic [1:0]  opcode;
		logic [3:0]  conn_slot;
		logic [7:0]  seg_flags;
		logic [31:0] seg_seq;
		logic [31:0] seg_ack;
		logic [15:0] ip_total_length;
		logic [3:0]  header_words;
		logic [15:0] send_length;
	} item_t;

	// One connection record as kept in the table memory.
	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] snd_seq;
		logic [31:0] rcv_ack;
	} conn_rec_t;

	// One result.
	typedef struct packed {
		logic [2:0]  outcome;
		logic        created;
		logic [1:0]  conn_status;
		logic [7:0]  reply_flags;
		logic [31:0] reply_seq;
		logic [31:0] reply_ack;
		logic [15:0] reply_window;
		logic [7:0]  reply_header_byte;
		logic [15:0] payload_length;
	} result_t;

	// Side effects of one processed request, from the update logic to the control.
	typedef struct packed {
		logic      tbl_we;
		conn_rec_t tbl_rec;
		logic      slot_valid;
		logic      isn_adv;
		logic [31:0] isn_next;
	} update_t;

endpackage

`default_nettype wire

@@ hdl/tpot_conn_ram.sv @@
// Connection table memory: one write port, one registered read port.
`default_nettype none

module tpot_conn_ram (
	input  wire logic                          clk,
	input  wire logic                          rd_en,
	input  wire logic [tpot_pkg::SLOT_W-1:0]   rd_addr,
	output tpot_pkg::conn_rec_t                rd_data,
	input  wire logic                          wr_en,
	input  wire logic [tpot_pkg::SLOT_W-1:0]   wr_addr,
	input  wire tpot_pkg::conn_rec_t           wr_data
);

	tpot_pkg::conn_rec_t mem_q [tpot_pkg::CONNECTIONS];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ hdl/tpot_apb_regs.sv @@
// Configuration registers behind the APB port.
`default_nettype none

module tpot_apb_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [tpot_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                      pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready,
	output logic [31:0]                           isn_seed,
	output logic [15:0]                           rx_window,
	output logic                                  isn_load
);

	logic [tpot_pkg::REG_IDX_W-1:0] reg_idx;
	logic                           wr_fire;
	logic [31:0]                    isn_seed_q;
	logic [15:0]                    rx_window_q;

	assign pready = 1'b1;
	assign reg_idx = paddr[tpot_pkg::APB_ADDR_W-1:2];
	assign wr_fire = psel && penable && pwrite && pready;

	// Register writes during the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			isn_seed_q <= tpot_pkg::ISN_SEED_RESET;
			rx_window_q <= tpot_pkg::RX_WINDOW_RESET;
		end else if (wr_fire) begin
			if (reg_idx == tpot_pkg::REG_ISN_SEED) begin
				isn_seed_q <= pwdata;
			end
			if (reg_idx == tpot_pkg::REG_RX_WINDOW) begin
				rx_window_q <= pwdata[15:0];
			end
		end
	end

	// Read-back mux.
	always_comb begin
		case (reg_idx)
			tpot_pkg::REG_ISN_SEED:  prdata = isn_seed_q;
			tpot_pkg::REG_RX_WINDOW: prdata = {16'd0, rx_window_q};
			default:                 prdata = 32'd0;
		endcase
	end

	// A seed write also reloads the sequence generator, with the value being written
	// so that the generator and the register take the new seed at the same edge.
	assign isn_load = wr_fire && (reg_idx == tpot_pkg::REG_ISN_SEED);
	assign isn_seed = pwdata;
	assign rx_window = rx_window_q;

endmodule

`default_nettype wire

@@ hdl/tpot_step_logic.sv @@
// Per-request update of one connection record and the result it produces.
`default_nettype none

module tpot_step_logic (
	input  wire tpot_pkg::item_t      item,
	input  wire logic                 in_range,
	input  wire logic                 slot_valid,
	input  wire tpot_pkg::conn_rec_t  rec_in,
	input  wire logic [31:0]          isn_cur,
	input  wire logic [15:0]          rx_window,
	output tpot_pkg::result_t         result,
	output tpot_pkg::update_t         upd
);

	always_comb begin
		tpot_pkg::conn_rec_t rec;
		logic                valid;
		logic [17:0]         pay;
		logic [31:0]         r;

		rec = rec_in;
		valid = slot_valid;
		r = item.seg_seq + 32'd1;
		pay = 18'(item.ip_total_length) - tpot_pkg::MIN_HDR_BYTES
			- 18'({item.header_words, 2'b00});
		result = '0;
		upd = '0;
		upd.isn_next = isn_cur + tpot_pkg::ISN_STEP;

		if (in_range) begin
			case (item.opcode)
				tpot_pkg::OP_SEGMENT: begin
					// A segment on a free slot opens it in LISTEN.
					if (!valid) begin
						valid = 1'b1;
						rec.status = tpot_pkg::ST_LISTEN;
						rec.snd_seq = upd.isn_next;
						rec.rcv_ack = 32'd0;
						upd.isn_adv = 1'b1;
						result.created = 1'b1;
					end
					case (rec.status)
						tpot_pkg::ST_LISTEN: begin
							if ((item.seg_flags & tpot_pkg::FLAG_SYN) != 8'd0) begin
								rec.rcv_ack = r;
								rec.status = tpot_pkg::ST_SYN_RECV;
								result.outcome = tpot_pkg::OC_SYNACK;
								result.reply_flags = tpot_pkg::FLAGS_SYNACK;
								result.reply_seq = rec.snd_seq;
								result.reply_ack = r;
								result.reply_window = rx_window;
								result.reply_header_byte = tpot_pkg::HDR_BYTE_FIVE;
							end
						end
						tpot_pkg::ST_SYN_RECV: begin
							if ((item.seg_flags & tpot_pkg::FLAG_ACK) != 8'd0) begin
								if (item.seg_ack == rec.snd_seq + 32'd1) begin
									rec.snd_seq = rec.snd_seq + 32'd1;
									rec.status = tpot_pkg::ST_ESTABLISHED;
									result.outcome = tpot_pkg::OC_ESTABLISHED;
								end else begin
									result.outcome = tpot_pkg::OC_ACK_MISMATCH;
								end
							end
						end
						tpot_pkg::ST_ESTABLISHED: begin
							// Payload is what the headers leave; a negative value counts as none.
							if (!pay[17] && (pay != 18'd0)) begin
								rec.rcv_ack = item.seg_seq + 32'(pay);
								result.payload_length = pay[15:0];
								result.outcome = tpot_pkg::OC_DELIVERED;
							end
						end
						default: begin
						end
					endcase
				end
				tpot_pkg::OP_SEND: begin
					if (!valid || (rec.status != tpot_pkg::ST_ESTABLISHED)) begin
						result.outcome = tpot_pkg::OC_SEND_REFUSED;
					end else if (item.send_length != 16'd0) begin
						result.outcome = tpot_pkg::OC_DATA_SENT;
						result.reply_flags = tpot_pkg::FLAGS_ACKPSH;
						result.reply_seq = rec.snd_seq;
						result.reply_ack = rec.rcv_ack;
						result.reply_window = rx_window;
						result.reply_header_byte = tpot_pkg::HDR_BYTE_FIVE;
						result.payload_length = item.send_length;
						rec.snd_seq = rec.snd_seq + 32'(item.send_length);
					end
				end
				tpot_pkg::OP_CLOSE: begin
					if (valid) begin
						valid = 1'b0;
						result.outcome = tpot_pkg::OC_CLOSED;
					end
				end
				default: begin
				end
			endcase
			result.conn_status = valid ? rec.status : tpot_pkg::ST_LISTEN;
			upd.tbl_we = 1'b1;
		end

		upd.tbl_rec = rec;
		upd.slot_valid = valid;
	end

endmodule

`default_nettype wire

@@ hdl/tcp_passive_open_tracker.sv @@
// Top level of the TCP passive-open tracker: stream ports, control and table.
// A request's record is read as it is accepted; its result is registered once the output is free.
// One request at a time: a new one is taken only after the last has done the read and then the write
// of the connection table memory.
// Reset clears every slot's valid bit, loads the sequence generator with the
// seed reset value and empties the stage and output registers; no clearing pass.
`default_nettype none

module tcp_passive_open_tracker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// s_tdata from bit 0: conn_slot, seg_flags, seg_seq, seg_ack, ip_total_length,
	// header_words, send_length
	input  wire logic [tpot_pkg::S_TDATA_W-1:0]      s_tdata,
	// s_tuser: opcode
	input  wire logic [tpot_pkg::S_TUSER_W-1:0]      s_tuser,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// m_tdata from bit 0: created, conn_status, reply_flags, reply_seq, reply_ack,
	// reply_window, reply_header_byte, payload_length, zero fill
	output logic [tpot_pkg::M_TDATA_W-1:0]           m_tdata,
	// m_tuser: outcome
	output logic [tpot_pkg::M_TUSER_W-1:0]           m_tuser,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [tpot_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire logic [31:0]                         pwdata,
	output logic [31:0]                              prdata,
	output logic                                     pready
);

	tpot_pkg::item_t             item_in;
	tpot_pkg::item_t             item_s1;
	logic                        v_s1;
	logic                        in_accept;
	logic                        fire_s1;
	logic [tpot_pkg::SLOT_W-1:0] slot_in;
	logic [tpot_pkg::SLOT_W-1:0] slot_s1;
	logic                        in_range_s1;
	logic [tpot_pkg::CONNECTIONS-1:0] slot_valid_q;
	logic [31:0]                 isn_q;
	logic [31:0]                 isn_seed;
	logic [15:0]                 rx_window;
	logic                        isn_load;
	tpot_pkg::conn_rec_t         rd_rec;
	tpot_pkg::result_t           result;
	tpot_pkg::update_t           upd;
	tpot_pkg::result_t           out_q;
	logic                        out_v_q;

	// Unpack the input request.
	assign item_in.opcode = s_tuser[1:0];
	assign item_in.conn_slot = s_tdata[3:0];
	assign item_in.seg_flags = s_tdata[11:4];
	assign item_in.seg_seq = s_tdata[43:12];
	assign item_in.seg_ack = s_tdata[75:44];
	assign item_in.ip_total_length = s_tdata[91:76];
	assign item_in.header_words = s_tdata[95:92];
	assign item_in.send_length = s_tdata[111:96];

	assign slot_in = tpot_pkg::SLOT_W'(item_in.conn_slot);
	assign slot_s1 = tpot_pkg::SLOT_W'(item_s1.conn_slot);
	assign in_range_s1 = 32'(item_s1.conn_slot) < 32'(tpot_pkg::CONNECTIONS);

	// One request in flight: it reads its record, then writes it back.
	assign s_tready = !v_s1;
	assign in_accept = s_tvalid && s_tready;
	assign fire_s1 = v_s1 && (!out_v_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_accept) begin
			v_s1 <= 1'b1;
		end else if (fire_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1 <= item_in;
		end
	end

	// Configuration registers.
	tpot_apb_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.isn_seed  (isn_seed),
		.rx_window (rx_window),
		.isn_load  (isn_load)
	);

	// Connection table.
	tpot_conn_ram u_ram (
		.clk     (clk),
		.rd_en   (in_accept),
		.rd_addr (slot_in),
		.rd_data (rd_rec),
		.wr_en   (fire_s1 && upd.tbl_we),
		.wr_addr (slot_s1),
		.wr_data (upd.tbl_rec)
	);

	// Record update and result.
	tpot_step_logic u_step (
		.item       (item_s1),
		.in_range   (in_range_s1),
		.slot_valid (slot_valid_q[slot_s1]),
		.rec_in     (rd_rec),
		.isn_cur    (isn_q),
		.rx_window  (rx_window),
		.result     (result),
		.upd        (upd)
	);

	// Slot valid bits and the sequence generator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			isn_q <= tpot_pkg::ISN_SEED_RESET;
		end else begin
			if (fire_s1 && upd.tbl_we) begin
				slot_valid_q[slot_s1] <= upd.slot_valid;
			end
			if (isn_load) begin
				isn_q <= isn_seed;
			end else if (fire_s1 && upd.isn_adv) begin
				isn_q <= upd.isn_next;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (fire_s1) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser = out_q.outcome;
	assign m_tdata = {5'd0, out_q.payload_length, out_q.reply_header_byte,
		out_q.reply_window, out_q.reply_ack, out_q.reply_seq, out_q.reply_flags,
		out_q.conn_status, out_q.created};

	// An accepted request is in the stage on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) in_accept |=> v_s1)
		else $error("accepted request did not reach the update stage");

	// A processed request always leaves a result behind.
	assert property (@(posedge clk) disable iff (!arst_n) fire_s1 |=> m_tvalid)
		else $error("processed request left no result");

	// Only emitted segments carry the fixed header byte, others carry no flags.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !(m_tuser == tpot_pkg::OC_SYNACK || m_tuser == tpot_pkg::OC_DATA_SENT)
		|-> (out_q.reply_flags == 8'd0) && (out_q.reply_header_byte == 8'd0))
		else $error("reply fields set without an emitted segment");

	// A closed connection reports status zero, the LISTEN code.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == tpot_pkg::OC_CLOSED) |-> (out_q.conn_status == 2'd0))
		else $error("closed connection reports a status");

	// The generator moves only by a seed load or when a request is processed.
	assert property (@(posedge clk) disable iff (!arst_n)
		!$past(isn_load) && !$past(fire_s1) |-> $stable(isn_q))
		else $error("sequence generator changed without cause");

endmodule

`default_nettype wire
